@@ rtl/msq_pkg.sv @@
`default_nettype none

package msq_pkg;

  localparam int TARGET_W    = 10;
  localparam int COUNT_W     = 3;
  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  // k*k runs up to 32*32 = 1024, one bit beyond the address range.
  localparam int KSQ_W       = ADDR_W + 1;
  localparam int SUM_W       = KSQ_W + 1;
  // Odd step 2k+1 for k up to 32.
  localparam int ODD_W       = 7;

  localparam logic [TARGET_W-1:0] MAX_N = TARGET_W'(1023);

  localparam logic [COUNT_W-1:0] COUNT_ZERO      = COUNT_W'(0);
  localparam logic [COUNT_W-1:0] COUNT_ONE       = COUNT_W'(1);
  localparam logic [COUNT_W-1:0] COUNT_MIN_INIT  = COUNT_W'(7);
  localparam logic [COUNT_W-1:0] COUNT_OUT_RANGE = COUNT_W'(7);

  typedef struct packed {
    logic load;    // latch a new target and seed the table
    logic issue;   // read the entry at v - k*k and step k
    logic commit;  // write the entry for v and move to v + 1
  } msq_cmd_t;

  typedef struct packed {
    logic trivial;       // target is zero or out of range
    logic next_exceeds;  // (k+1)^2 is beyond v
    logic last_value;    // v has reached the target
  } msq_sts_t;

endpackage

`default_nettype wire

@@ rtl/msq_datapath.sv @@
`default_nettype none

module msq_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [msq_pkg::TARGET_W-1:0]   target,
  input  wire msq_pkg::msq_cmd_t              cmd,
  output msq_pkg::msq_sts_t                   sts,
  output logic      [msq_pkg::COUNT_W-1:0]    square_count
);
  import msq_pkg::*;

  logic [COUNT_W-1:0]  mem [TABLE_DEPTH];
  logic [TARGET_W-1:0] n;
  logic [ADDR_W-1:0]   v;
  logic [KSQ_W-1:0]    ksq;
  logic [ODD_W-1:0]    odd;
  logic [COUNT_W-1:0]  minv;
  logic [COUNT_W-1:0]  rd_data;
  logic                rd_valid;
  logic [COUNT_W-1:0]  result;

  logic [SUM_W-1:0]    ksq_sum;
  logic [ADDR_W-1:0]   rd_addr;
  logic [ADDR_W-1:0]   wr_addr;
  logic [COUNT_W-1:0]  wr_data;
  logic [COUNT_W-1:0]  best;
  logic                tgt_zero;

  assign ksq_sum  = {1'b0, ksq} + SUM_W'(odd);
  assign rd_addr  = v - ksq[ADDR_W-1:0];
  assign best     = minv + COUNT_ONE;
  assign wr_addr  = cmd.load ? ADDR_W'(0) : v;
  assign wr_data  = cmd.load ? COUNT_ZERO : best;
  assign tgt_zero = (target == TARGET_W'(0));

  assign sts.trivial      = tgt_zero || (target > MAX_N);
  assign sts.next_exceeds = ksq_sum > SUM_W'(v);
  assign sts.last_value   = (TARGET_W'(v) == n);

  assign square_count = result;

  // Scratch table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.load || cmd.commit) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.issue) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n    <= target;
      v    <= ADDR_W'(1);
      ksq  <= KSQ_W'(1);
      odd  <= ODD_W'(3);
      minv <= COUNT_MIN_INIT;
      if (tgt_zero) begin
        result <= COUNT_ZERO;
      end else if (target > MAX_N) begin
        result <= COUNT_OUT_RANGE;
      end
    end else if (cmd.commit) begin
      v    <= v + ADDR_W'(1);
      ksq  <= KSQ_W'(1);
      odd  <= ODD_W'(3);
      minv <= COUNT_MIN_INIT;
      if (sts.last_value) begin
        result <= best;
      end
    end else begin
      if (cmd.issue) begin
        ksq <= ksq_sum[KSQ_W-1:0];
        odd <= odd + ODD_W'(2);
      end
      // Read data lands in the cycle after its issue and is folded into the minimum.
      if (rd_valid && (rd_data < minv)) begin
        minv <= rd_data;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/msq_ctrl.sv @@
`default_nettype none

module msq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire msq_pkg::msq_sts_t  sts,
  output msq_pkg::msq_cmd_t       cmd,
  output logic                    busy,
  output logic                    done
);
  import msq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_WRITE
  } state_t;

  state_t state;

  assign cmd.load   = (state == ST_IDLE) && start;
  assign cmd.issue  = (state == ST_READ);
  assign cmd.commit = (state == ST_WRITE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            if (sts.trivial) begin
              done <= 1'b1;
            end else begin
              busy  <= 1'b1;
              state <= ST_READ;
            end
          end
        end
        ST_READ: begin
          if (sts.next_exceeds) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_WRITE;
        end
        ST_WRITE: begin
          if (sts.last_value) begin
            busy  <= 1'b0;
            done  <= 1'b1;
            state <= ST_IDLE;
          end else begin
            state <= ST_READ;
          end
        end
        default: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  a_busy_matches_state: assert property (@(posedge clk) disable iff (rst)
    busy == (state != ST_IDLE))
    else $error("busy disagrees with controller state");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobed while still busy");

  a_drain_to_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |=> (state == ST_WRITE))
    else $error("drain not followed by table write");

  a_trivial_answers_at_once: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && sts.trivial) |=> (done && !busy))
    else $error("trivial target not answered in one cycle");

  a_work_starts: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !sts.trivial) |=> (busy && !done))
    else $error("accepted target did not start the table fill");

endmodule

`default_nettype wire

@@ rtl/min_perfect_square_count.sv @@
`default_nettype none

// Least number of perfect squares that sum to a target value.
// Command channel: a transaction is accepted at a rising edge where start is
// high and busy is low; target is sampled at that edge. busy goes high at that
// same edge and stays high until the cycle in which the answer is strobed.
// Result channel: done is high for exactly one cycle, with square_count
// valid in that same cycle. The receiver cannot stall, so the result must
// be taken when it is strobed.
// A target of zero answers with 0 in the cycle after acceptance, and busy
// never rises. Otherwise the scratch table is rebuilt for every value v
// from 1 to the target: the entries at v - k*k are read for each k with
// k*k <= v, the last read drains, and the entry for v is written. The
// single read port of the scratch table gives one entry read per cycle
// in the read phase. One transaction is in flight at a time.
// Reset (synchronous, active high) returns the controller to idle with
// busy and done low; the table contents need no clearing.
module min_perfect_square_count (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [msq_pkg::TARGET_W-1:0]  target,
  output logic                               busy,
  output logic                               done,
  output logic      [msq_pkg::COUNT_W-1:0]   square_count
);
  import msq_pkg::*;

  msq_cmd_t cmd;
  msq_sts_t sts;

  msq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  msq_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .target       (target),
    .cmd          (cmd),
    .sts          (sts),
    .square_count (square_count)
  );

endmodule

`default_nettype wire
